### design/spot_pkg.sv
package spot_pkg;

	// Shape kind codes as they arrive on the input channel.
	localparam logic [2:0] KIND_UNDEF  = 3'd0;
	localparam logic [2:0] KIND_OBB    = 3'd1;
	localparam logic [2:0] KIND_AABB   = 3'd2;
	localparam logic [2:0] KIND_PLANE  = 3'd3;
	localparam logic [2:0] KIND_SPHERE = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_TESTED      = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_UNDEFINED   = 2'd2;

	localparam int unsigned CoordW = 32;
	localparam int unsigned RadW   = 31;
	localparam int unsigned SqW    = 2 * CoordW;

	// One shape: points are signed Q16.16 kept as raw bits.
	typedef struct packed {
		logic [2:0]                   kind;
		logic [2:0][CoordW-1:0]       lo;
		logic [2:0][CoordW-1:0]       hi;
		logic [RadW-1:0]              rad;
	} shape_t;

	// Outcome of the distance stage for one test transaction.
	typedef struct packed {
		logic [1:0]                   status;
		logic                         use_dist;
		logic                         box_hit;
		logic [2:0][CoordW-1:0]       gap;
		logic [CoordW-1:0]            lim;
	} prep_t;

endpackage

### design/spot_in_if.sv
interface spot_in_if;
	logic              valid;
	logic              ready;
	logic              action;
	logic [2:0]        kind;
	logic signed [31:0] p_x;
	logic signed [31:0] p_y;
	logic signed [31:0] p_z;
	logic signed [31:0] q_x;
	logic signed [31:0] q_y;
	logic signed [31:0] q_z;
	logic [30:0]       radius;

	modport source (
		output valid, action, kind, p_x, p_y, p_z, q_x, q_y, q_z, radius,
		input  ready
	);
	modport sink (
		input  valid, action, kind, p_x, p_y, p_z, q_x, q_y, q_z, radius,
		output ready
	);
endinterface

### design/spot_out_if.sv
interface spot_out_if;
	logic       valid;
	logic       ready;
	logic       colliding;
	logic [1:0] status;

	modport source (
		output valid, colliding, status,
		input  ready
	);
	modport sink (
		input  valid, colliding, status,
		output ready
	);
endinterface

### design/spot_prep.sv
// Classifies a shape pair and reduces it to per-axis distances and a limit.
module spot_prep (
	input  spot_pkg::shape_t held,
	input  spot_pkg::shape_t probe,
	output spot_pkg::prep_t  prep
);

	logic                 held_def;
	logic                 probe_def;
	logic                 both_box;
	logic                 both_sph;
	logic                 box_sph;
	logic                 sph_box;
	logic [2:0]           axis_hit;
	spot_pkg::shape_t     box;
	spot_pkg::shape_t     sph;
	logic signed [32:0]   c;
	logic signed [32:0]   lo;
	logic signed [32:0]   hi;
	logic signed [32:0]   ca;
	logic signed [32:0]   cb;
	logic signed [32:0]   diff;
	logic [2:0][31:0]     dist_bs;
	logic [2:0][31:0]     dist_ss;

	function automatic logic kind_ok(input logic [2:0] k);
		return (k == spot_pkg::KIND_OBB) || (k == spot_pkg::KIND_AABB) ||
			(k == spot_pkg::KIND_PLANE) || (k == spot_pkg::KIND_SPHERE);
	endfunction

	always_comb begin
		held_def  = kind_ok(held.kind);
		probe_def = kind_ok(probe.kind);
		both_box  = (held.kind == spot_pkg::KIND_AABB) && (probe.kind == spot_pkg::KIND_AABB);
		both_sph  = (held.kind == spot_pkg::KIND_SPHERE) &&
			(probe.kind == spot_pkg::KIND_SPHERE);
		box_sph   = (held.kind == spot_pkg::KIND_AABB) && (probe.kind == spot_pkg::KIND_SPHERE);
		sph_box   = (held.kind == spot_pkg::KIND_SPHERE) && (probe.kind == spot_pkg::KIND_AABB);

		box = sph_box ? probe : held;
		sph = sph_box ? held : probe;

		for (int i = 0; i < 3; i++) begin
			axis_hit[i] = ($signed(held.lo[i]) <= $signed(probe.hi[i])) &&
				($signed(held.hi[i]) >= $signed(probe.lo[i]));

			// Distance from the sphere center to the box, clamped per axis.
			// The maximum is tested first so an inverted box behaves as specified.
			c  = 33'($signed(sph.lo[i]));
			lo = 33'($signed(box.lo[i]));
			hi = 33'($signed(box.hi[i]));
			if (c > hi) begin
				diff = c - hi;
			end else if (c < lo) begin
				diff = lo - c;
			end else begin
				diff = '0;
			end
			dist_bs[i] = diff[31:0];

			ca = 33'($signed(held.lo[i]));
			cb = 33'($signed(probe.lo[i]));
			diff = (ca >= cb) ? (ca - cb) : (cb - ca);
			dist_ss[i] = diff[31:0];
		end

		prep.box_hit  = 1'b0;
		prep.use_dist = 1'b0;
		prep.gap      = both_sph ? dist_ss : dist_bs;
		prep.lim      = both_sph ? ({1'b0, held.rad} + {1'b0, probe.rad}) : {1'b0, sph.rad};

		if (!held_def || !probe_def) begin
			prep.status = spot_pkg::ST_UNDEFINED;
		end else if (both_box) begin
			prep.status  = spot_pkg::ST_TESTED;
			prep.box_hit = &axis_hit;
		end else if (box_sph || sph_box || both_sph) begin
			prep.status   = spot_pkg::ST_TESTED;
			prep.use_dist = 1'b1;
		end else begin
			prep.status = spot_pkg::ST_UNSUPPORTED;
		end
	end

endmodule

### design/shape_pair_overlap_test_core.sv
// Channel   Role    Payload
// shapes    sink    action, kind, p_x/p_y/p_z, q_x/q_y/q_z, radius
// results   source  colliding, status
//
// A transaction with action 0 loads the held shape at its acceptance edge and yields no result.
// A test transaction passes the input register, the distance stage, the squaring stage with its
// four 32x32 squarers, and the result register before its result is offered. One transaction
// can be accepted every cycle until a results stall has filled every stage. Reset clears the held
// shape to the undefined kind and empties the pipeline. When results stalls, the stages fill up
// behind the result register and shapes.ready drops only once every stage holds a test.
module shape_pair_overlap_test_core (
	input  logic       clk,
	input  logic       arst_n,
	spot_in_if.sink    shapes,
	spot_out_if.source results
);

	// Held shape, loaded by hold transactions.
	spot_pkg::shape_t held_q;

	// Stage 1: the probe shape and a snapshot of the held shape.
	logic              valid_s1;
	spot_pkg::shape_t  held_s1;
	spot_pkg::shape_t  probe_s1;

	// Stage 2: classification, per-axis distances and the limit.
	logic              valid_s2;
	spot_pkg::prep_t   prep_s2;

	// Stage 3: squared distances and squared limit.
	logic              valid_s3;
	logic [1:0]        status_s3;
	logic              use_dist_s3;
	logic              box_hit_s3;
	logic [2:0][spot_pkg::SqW-1:0] sq_s3;
	logic [spot_pkg::SqW-1:0]      lim_sq_s3;

	// Result register.
	logic              out_valid_q;
	logic              colliding_q;
	logic [1:0]        status_q;

	spot_pkg::shape_t  probe_in;
	spot_pkg::prep_t   prep_w;
	logic              go_out;
	logic              go_3;
	logic              go_2;
	logic              go_1;
	logic              accept;
	logic [spot_pkg::SqW+1:0] sum_w;
	logic              dist_hit;

	// A stage takes new data when it is empty or its contents move on.
	assign go_out = !out_valid_q || results.ready;
	assign go_3   = !valid_s3 || go_out;
	assign go_2   = !valid_s2 || go_3;
	assign go_1   = !valid_s1 || go_2;

	assign shapes.ready = go_1;
	assign accept       = shapes.valid && go_1;

	always_comb begin
		probe_in.kind  = shapes.kind;
		probe_in.lo[0] = shapes.p_x;
		probe_in.lo[1] = shapes.p_y;
		probe_in.lo[2] = shapes.p_z;
		probe_in.hi[0] = shapes.q_x;
		probe_in.hi[1] = shapes.q_y;
		probe_in.hi[2] = shapes.q_z;
		probe_in.rad   = shapes.radius;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && !shapes.action) begin
				held_q <= probe_in;
			end
			if (go_1) begin
				valid_s1 <= accept && shapes.action;
			end
			if (go_2) begin
				valid_s2 <= valid_s1;
			end
			if (go_3) begin
				valid_s3 <= valid_s2;
			end
			if (go_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	spot_prep u_prep (
		.held  (held_s1),
		.probe (probe_s1),
		.prep  (prep_w)
	);

	// The held snapshot is taken before any hold in the same edge can land,
	// since a transaction carries only one action.
	always_ff @(posedge clk) begin
		if (go_1) begin
			held_s1  <= held_q;
			probe_s1 <= probe_in;
		end
		if (go_2) begin
			prep_s2 <= prep_w;
		end
		if (go_3) begin
			status_s3   <= prep_s2.status;
			use_dist_s3 <= prep_s2.use_dist;
			box_hit_s3  <= prep_s2.box_hit;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= 64'(prep_s2.gap[i]) * 64'(prep_s2.gap[i]);
			end
			lim_sq_s3 <= 64'(prep_s2.lim) * 64'(prep_s2.lim);
		end
		if (go_out) begin
			colliding_q <= (status_s3 == spot_pkg::ST_TESTED) &&
				(use_dist_s3 ? dist_hit : box_hit_s3);
			status_q    <= status_s3;
		end
	end

	// Exact sum of squares; two extra bits keep it from wrapping.
	assign sum_w    = {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
	assign dist_hit = sum_w <= {2'b00, lim_sq_s3};

	assign results.valid     = out_valid_q;
	assign results.colliding = colliding_q;
	assign results.status    = status_q;

endmodule
